// File: hdl/cir_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cir_pkg
// Shared types, constants and saturating fixed-point helpers for the contact
// impulse resolver.
// ----------------------------------------------------------------------------
package cir_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int RATIO_BITS = 16;
  localparam int RATIO_ONE  = 65536;
  localparam int DATA_W     = 32;
  localparam int MUL_W      = DATA_W + 1;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int DIV_W      = DATA_W + FRAC_BITS + 1;
  localparam int SQ_STEPS   = 32;
  localparam int QDEPTH     = 2;

  localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    OUT_FULL,
    OUT_SEPARATING,
    OUT_IMMOVABLE,
    OUT_NO_FRICTION
  } outcome_t;

  typedef enum logic [1:0] {
    CFG_RESTITUTION,
    CFG_STATIC_RATIO,
    CFG_DYNAMIC_RATIO,
    CFG_TOLERANCE
  } cfg_idx_t;

  typedef struct packed {
    logic [16:0] restitution;
    logic [16:0] static_ratio;
    logic [16:0] dynamic_ratio;
    logic [15:0] tolerance;
  } cfg_t;

  typedef struct packed {
    logic [63:0]        a_pos;
    logic [63:0]        b_pos;
    logic [63:0]        a_vel;
    logic [63:0]        b_vel;
    logic [63:0]        point;
    logic [63:0]        normal;
    logic signed [31:0] a_spin;
    logic signed [31:0] b_spin;
    logic [30:0]        a_inv_inertia;
    logic [30:0]        b_inv_inertia;
    logic signed [31:0] msum;
    logic               immovable;
  } item_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_CHK,
    ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7, ST_M8, ST_M9, ST_M10,
    ST_M11, ST_M12, ST_M13, ST_M14, ST_M15, ST_M16, ST_M17, ST_M18, ST_M19,
    ST_M20, ST_WJ, ST_P1, ST_P2, ST_WTX, ST_WTY, ST_J1, ST_J2, ST_WJT,
    ST_F1, ST_F2, ST_F3, ST_F4
  } bk_state_t;

  function automatic logic signed [67:0] ext68(input logic signed [31:0] a);
    return 68'(a);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    if (v > 68'sd2147483647) return S_MAX;
    if (v < -68'sd2147483648) return S_MIN;
    return $signed(v[31:0]);
  endfunction

  function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return sat32(ext68(a) + ext68(b));
  endfunction

  function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return sat32(ext68(a) - ext68(b));
  endfunction

  function automatic logic signed [31:0] neg_sat(input logic signed [31:0] a);
    return sat32(-ext68(a));
  endfunction

  // round half away from zero, then saturate
  function automatic logic signed [31:0] rnd_sat(input logic signed [65:0] p,
                                                 input int s);
    logic [65:0] mag;
    logic [65:0] r;
    mag = p[65] ? 66'(-p) : 66'(p);
    r = (mag + (66'd1 << (s - 1))) >> s;
    if (p[65]) return sat32(-$signed({2'b00, r}));
    return sat32($signed({2'b00, r}));
  endfunction

  function automatic logic is_zero(input logic signed [31:0] v,
                                   input logic [15:0] tol);
    logic [32:0] mag;
    mag = v[31] ? 33'(-ext68(v)) : 33'(ext68(v));
    return mag < {17'd0, tol};
  endfunction

endpackage

// File: hdl/cir_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cir_div
// Bit-serial rounded fixed-point divider, one quotient bit per cycle,
// saturating result.
// ----------------------------------------------------------------------------
module cir_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [33:0] den,
  output logic               busy,
  output logic signed [31:0] quo
);

  logic [cir_pkg::DIV_W-1:0]         dvd;
  logic [cir_pkg::DIV_W-1:0]         q;
  logic [32:0]                       rem;
  logic [32:0]                       ud;
  logic                              neg;
  logic [$clog2(cir_pkg::DIV_W+1)-1:0] cnt;
  logic [32:0]                       un;
  logic [32:0]                       ud_in;
  logic [33:0]                       rsh;
  logic                              qbit;

  assign un    = num[31] ? 33'(-cir_pkg::ext68(num)) : 33'(cir_pkg::ext68(num));
  assign ud_in = den[33] ? 33'(-den) : den[32:0];
  assign rsh   = {rem, dvd[cir_pkg::DIV_W-1]};
  assign qbit  = rsh >= {1'b0, ud};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      if (den == 34'sd0) begin
        busy <= 1'b0;
        if (num == 32'sd0) quo <= 32'sd0;
        else quo <= num[31] ? cir_pkg::S_MIN : cir_pkg::S_MAX;
      end else begin
        busy <= 1'b1;
        cnt  <= ($clog2(cir_pkg::DIV_W+1))'(cir_pkg::DIV_W);
        dvd  <= (cir_pkg::DIV_W'(un) << cir_pkg::FRAC_BITS) + cir_pkg::DIV_W'(ud_in >> 1);
        ud   <= ud_in;
        rem  <= '0;
        q    <= '0;
        neg  <= num[31] ^ den[33];
      end
    end else if (busy) begin
      if (cnt != '0) begin
        rem <= qbit ? 33'(rsh - {1'b0, ud}) : rsh[32:0];
        q   <= {q[cir_pkg::DIV_W-2:0], qbit};
        dvd <= dvd << 1;
        cnt <= cnt - ($clog2(cir_pkg::DIV_W+1))'(1);
      end else begin
        busy <= 1'b0;
        if (|q[cir_pkg::DIV_W-1:31]) quo <= neg ? cir_pkg::S_MIN : cir_pkg::S_MAX;
        else quo <= neg ? -$signed(q[31:0]) : $signed(q[31:0]);
      end
    end
  end

endmodule

// File: hdl/cir_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cir_sqrt
// Integer square root of a 64-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module cir_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] x,
  output logic        busy,
  output logic [31:0] root
);

  logic [63:0] xs;
  logic [33:0] rem;
  logic [5:0]  cnt;
  logic [35:0] rsh;
  logic [35:0] trial;

  assign rsh   = {rem, xs[63:62]};
  assign trial = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'(cir_pkg::SQ_STEPS);
      xs   <= x;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      if (rsh >= trial) begin
        rem  <= 34'(rsh - trial);
        root <= {root[30:0], 1'b1};
      end else begin
        rem  <= rsh[33:0];
        root <= {root[30:0], 1'b0};
      end
      xs  <= xs << 2;
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) busy <= 1'b0;
    end
  end

endmodule

// File: hdl/cir_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cir_front
// Accepts contacts, flags immovable pairs and queues them for the back end.
// ----------------------------------------------------------------------------
module cir_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [63:0]        body_a_position,
  input  logic [63:0]        body_b_position,
  input  logic [63:0]        body_a_velocity,
  input  logic [63:0]        body_b_velocity,
  input  logic [63:0]        contact_point,
  input  logic [63:0]        contact_normal,
  input  logic signed [31:0] body_a_spin,
  input  logic signed [31:0] body_b_spin,
  input  logic [30:0]        body_a_inv_mass,
  input  logic [30:0]        body_b_inv_mass,
  input  logic [30:0]        body_a_inv_inertia,
  input  logic [30:0]        body_b_inv_inertia,
  input  logic [15:0]        tolerance,
  output logic               q_valid,
  input  logic               pop,
  output cir_pkg::item_t     q_item
);

  cir_pkg::item_t ent [cir_pkg::QDEPTH];
  cir_pkg::item_t new_item;
  logic [$clog2(cir_pkg::QDEPTH)-1:0] wp;
  logic [$clog2(cir_pkg::QDEPTH)-1:0] rp;
  logic [$clog2(cir_pkg::QDEPTH+1)-1:0] cnt;
  logic push;
  logic do_pop;
  logic signed [31:0] msum;

  assign busy    = cnt == ($clog2(cir_pkg::QDEPTH+1))'(cir_pkg::QDEPTH);
  assign q_valid = cnt != '0;
  assign push    = start && !busy;
  assign do_pop  = pop && q_valid;
  assign q_item  = ent[rp];
  assign msum    = cir_pkg::add_sat($signed({1'b0, body_a_inv_mass}),
                                    $signed({1'b0, body_b_inv_mass}));

  always_comb begin
    new_item.a_pos         = body_a_position;
    new_item.b_pos         = body_b_position;
    new_item.a_vel         = body_a_velocity;
    new_item.b_vel         = body_b_velocity;
    new_item.point         = contact_point;
    new_item.normal        = contact_normal;
    new_item.a_spin        = body_a_spin;
    new_item.b_spin        = body_b_spin;
    new_item.a_inv_inertia = body_a_inv_inertia;
    new_item.b_inv_inertia = body_b_inv_inertia;
    new_item.msum          = msum;
    new_item.immovable     = cir_pkg::is_zero(msum, tolerance);
  end

  always_ff @(posedge clk) begin
    if (push) ent[wp] <= new_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (do_pop) rp <= rp + 1'b1;
      cnt <= cnt + ($clog2(cir_pkg::QDEPTH+1))'(push)
                 - ($clog2(cir_pkg::QDEPTH+1))'(do_pop);
    end
  end

endmodule

// File: hdl/cir_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cir_back
// Sequencer over one shared multiplier, a serial divider and a square root
// unit; computes the impulse of one queued contact.
// ----------------------------------------------------------------------------
module cir_back (
  input  logic               clk,
  input  logic               rst,
  input  cir_pkg::cfg_t      cfg,
  input  logic               q_valid,
  output logic               pop,
  input  cir_pkg::item_t     q_item,
  output logic               done,
  output logic signed [31:0] impulse_x,
  output logic signed [31:0] impulse_y,
  output logic [1:0]         outcome
);

  cir_pkg::bk_state_t st;
  cir_pkg::bk_state_t st_next;
  cir_pkg::item_t     it;

  logic signed [31:0] c1x, c1y, c2x, c2y, rx, ry, cv, tmp, tmp2, x1, x2;
  logic signed [31:0] ims, jj, ix, iy, tx, ty, tnx, tny, jt, fr;
  logic [63:0]        sq;
  logic [31:0]        len;

  logic signed [cir_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [cir_pkg::PROD_W-1:0] prod;
  logic signed [31:0] rf, rr;

  logic               div_start, div_busy;
  logic signed [31:0] div_n, div_q;
  logic signed [33:0] div_d;
  logic               sq_start, sq_busy;
  logic [63:0]        sq_x;
  logic [31:0]        sq_root;

  logic signed [31:0] pax, pay, pbx, pby, vax, vay, vbx, vby, cpx, cpy, nx, ny;
  logic [17:0]        rest_one;
  logic signed [33:0] aj_s;
  logic               fric_static;

  assign pax = $signed(it.a_pos[31:0]);  assign pay = $signed(it.a_pos[63:32]);
  assign pbx = $signed(it.b_pos[31:0]);  assign pby = $signed(it.b_pos[63:32]);
  assign vax = $signed(it.a_vel[31:0]);  assign vay = $signed(it.a_vel[63:32]);
  assign vbx = $signed(it.b_vel[31:0]);  assign vby = $signed(it.b_vel[63:32]);
  assign cpx = $signed(it.point[31:0]);  assign cpy = $signed(it.point[63:32]);
  assign nx  = $signed(it.normal[31:0]); assign ny  = $signed(it.normal[63:32]);

  assign rest_one = 18'(cir_pkg::RATIO_ONE) + {1'b0, cfg.restitution};
  assign rf = cir_pkg::rnd_sat(prod, cir_pkg::FRAC_BITS);
  assign rr = cir_pkg::rnd_sat(prod, cir_pkg::RATIO_BITS);
  assign aj_s = jt[31] ? -34'(jt) : 34'(jt);
  assign fric_static = aj_s < 34'(rr);
  assign sq_x = sq + prod[63:0];

  cir_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_n), .den(div_d),
    .busy(div_busy), .quo(div_q)
  );

  cir_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .x(sq_x), .busy(sq_busy),
    .root(sq_root)
  );

  always_comb begin
    st_next = st;
    case (st)
      cir_pkg::ST_IDLE: if (q_valid) st_next = cir_pkg::ST_CHK;
      cir_pkg::ST_CHK:  st_next = it.immovable ? cir_pkg::ST_IDLE : cir_pkg::ST_M1;
      cir_pkg::ST_M1:   st_next = cir_pkg::ST_M2;
      cir_pkg::ST_M2:   st_next = cir_pkg::ST_M3;
      cir_pkg::ST_M3:   st_next = cir_pkg::ST_M4;
      cir_pkg::ST_M4:   st_next = cir_pkg::ST_M5;
      cir_pkg::ST_M5:   st_next = cir_pkg::ST_M6;
      cir_pkg::ST_M6:   st_next = cir_pkg::ST_M7;
      cir_pkg::ST_M7:   st_next = cir_pkg::ST_M8;
      cir_pkg::ST_M8:   st_next = (cv > 32'sd0) ? cir_pkg::ST_IDLE : cir_pkg::ST_M9;
      cir_pkg::ST_M9:   st_next = cir_pkg::ST_M10;
      cir_pkg::ST_M10:  st_next = cir_pkg::ST_M11;
      cir_pkg::ST_M11:  st_next = cir_pkg::ST_M12;
      cir_pkg::ST_M12:  st_next = cir_pkg::ST_M13;
      cir_pkg::ST_M13:  st_next = cir_pkg::ST_M14;
      cir_pkg::ST_M14:  st_next = cir_pkg::ST_M15;
      cir_pkg::ST_M15:  st_next = cir_pkg::ST_M16;
      cir_pkg::ST_M16:  st_next = cir_pkg::ST_M17;
      cir_pkg::ST_M17:  st_next = cir_pkg::ST_M18;
      cir_pkg::ST_M18:  st_next = cir_pkg::ST_M19;
      cir_pkg::ST_M19:  st_next = cir_pkg::ST_M20;
      cir_pkg::ST_M20:  st_next = cir_pkg::ST_WJ;
      cir_pkg::ST_WJ:   if (!div_busy && !sq_busy) st_next = cir_pkg::ST_P1;
      cir_pkg::ST_P1:   st_next = cir_pkg::ST_P2;
      cir_pkg::ST_P2:   st_next = cir_pkg::ST_WTX;
      cir_pkg::ST_WTX:  if (!div_busy) st_next = cir_pkg::ST_WTY;
      cir_pkg::ST_WTY:  if (!div_busy) st_next = cir_pkg::ST_J1;
      cir_pkg::ST_J1:   st_next = cir_pkg::ST_J2;
      cir_pkg::ST_J2:   st_next = cir_pkg::ST_WJT;
      cir_pkg::ST_WJT:  if (!div_busy) st_next = cir_pkg::ST_F1;
      cir_pkg::ST_F1: begin
        if (cir_pkg::is_zero(jt, cfg.tolerance)) st_next = cir_pkg::ST_IDLE;
        else if (fric_static) st_next = cir_pkg::ST_F3;
        else st_next = cir_pkg::ST_F2;
      end
      cir_pkg::ST_F2:   st_next = cir_pkg::ST_F3;
      cir_pkg::ST_F3:   st_next = cir_pkg::ST_F4;
      cir_pkg::ST_F4:   st_next = cir_pkg::ST_IDLE;
      default:          st_next = cir_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_n     = '0;
    div_d     = '0;
    sq_start  = 1'b0;
    pop       = 1'b0;
    case (st)
      cir_pkg::ST_IDLE: pop = q_valid;
      cir_pkg::ST_M1:  begin mul_a = 33'(it.b_spin); mul_b = 33'(c2y); end
      cir_pkg::ST_M2:  begin mul_a = 33'(it.b_spin); mul_b = 33'(c2x); end
      cir_pkg::ST_M3:  begin mul_a = 33'(it.a_spin); mul_b = 33'(c1y); end
      cir_pkg::ST_M4:  begin mul_a = 33'(it.a_spin); mul_b = 33'(c1x); end
      cir_pkg::ST_M5:  begin mul_a = 33'(rx); mul_b = 33'(nx); end
      cir_pkg::ST_M6:  begin mul_a = 33'(ry); mul_b = 33'(ny); end
      cir_pkg::ST_M7:  begin mul_a = 33'(c1x); mul_b = 33'(ny); end
      cir_pkg::ST_M8:  begin mul_a = 33'(c1y); mul_b = 33'(nx); end
      cir_pkg::ST_M9:  begin mul_a = 33'(c2x); mul_b = 33'(ny); end
      cir_pkg::ST_M10: begin mul_a = 33'(c2y); mul_b = 33'(nx); end
      cir_pkg::ST_M11: begin mul_a = 33'(x1); mul_b = 33'(x1); end
      cir_pkg::ST_M12: begin mul_a = 33'(x2); mul_b = 33'(x2); end
      cir_pkg::ST_M13: begin mul_a = 33'(tmp); mul_b = $signed({2'b00, it.a_inv_inertia}); end
      cir_pkg::ST_M14: begin mul_a = 33'(tmp2); mul_b = $signed({2'b00, it.b_inv_inertia}); end
      cir_pkg::ST_M15: begin mul_a = 33'(cv); mul_b = $signed(33'(rest_one)); end
      cir_pkg::ST_M16: begin
        mul_a = 33'(nx); mul_b = 33'(cv);
        div_start = 1'b1; div_n = cir_pkg::neg_sat(rr); div_d = 34'(ims);
      end
      cir_pkg::ST_M17: begin mul_a = 33'(ny); mul_b = 33'(cv); end
      cir_pkg::ST_M18: begin mul_a = 33'(tx); mul_b = 33'(tx); end
      cir_pkg::ST_M19: begin mul_a = 33'(ty); mul_b = 33'(ty); end
      cir_pkg::ST_M20: sq_start = 1'b1;
      cir_pkg::ST_WJ: begin
        mul_a = 33'(nx); mul_b = 33'(div_q);
        if (!div_busy && !sq_busy) begin
          div_start = 1'b1; div_n = tx; div_d = $signed({2'b00, sq_root});
        end
      end
      cir_pkg::ST_P1:  begin mul_a = 33'(ny); mul_b = 33'(jj); end
      cir_pkg::ST_WTX: if (!div_busy) begin
        div_start = 1'b1; div_n = ty; div_d = $signed({2'b00, len});
      end
      cir_pkg::ST_WTY: begin mul_a = 33'(rx); mul_b = 33'(tnx); end
      cir_pkg::ST_J1:  begin mul_a = 33'(ry); mul_b = 33'(tny); end
      cir_pkg::ST_J2: begin
        div_start = 1'b1;
        div_n = cir_pkg::neg_sat(cir_pkg::add_sat(tmp, rf));
        div_d = 34'(ims);
      end
      cir_pkg::ST_WJT: begin mul_a = 33'(jj); mul_b = $signed({16'd0, cfg.static_ratio}); end
      cir_pkg::ST_F1: begin
        if (fric_static) begin
          mul_a = 33'(tnx); mul_b = 33'(jt);
        end else begin
          mul_a = 33'(cir_pkg::neg_sat(jj)); mul_b = $signed({16'd0, cfg.dynamic_ratio});
        end
      end
      cir_pkg::ST_F2:  begin mul_a = 33'(tnx); mul_b = 33'(rr); end
      cir_pkg::ST_F3:  begin mul_a = 33'(tny); mul_b = 33'(fr); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= cir_pkg::ST_IDLE;
      done <= 1'b0;
    end else begin
      st   <= st_next;
      done <= (st == cir_pkg::ST_CHK && it.immovable) ||
              (st == cir_pkg::ST_M8 && cv > 32'sd0) ||
              (st == cir_pkg::ST_F1 && cir_pkg::is_zero(jt, cfg.tolerance)) ||
              (st == cir_pkg::ST_F4);
    end
  end

  always_ff @(posedge clk) begin
    prod <= cir_pkg::PROD_W'(mul_a) * cir_pkg::PROD_W'(mul_b);
    case (st)
      cir_pkg::ST_IDLE: if (q_valid) it <= q_item;
      cir_pkg::ST_CHK: begin
        c1x <= cir_pkg::sub_sat(cpx, pax); c1y <= cir_pkg::sub_sat(cpy, pay);
        c2x <= cir_pkg::sub_sat(cpx, pbx); c2y <= cir_pkg::sub_sat(cpy, pby);
        impulse_x <= '0; impulse_y <= '0; outcome <= cir_pkg::OUT_IMMOVABLE;
      end
      cir_pkg::ST_M2:  rx <= cir_pkg::sub_sat(vbx, rf);
      cir_pkg::ST_M3:  ry <= cir_pkg::add_sat(vby, rf);
      cir_pkg::ST_M4:  rx <= cir_pkg::add_sat(cir_pkg::sub_sat(rx, vax), rf);
      cir_pkg::ST_M5:  ry <= cir_pkg::sub_sat(cir_pkg::sub_sat(ry, vay), rf);
      cir_pkg::ST_M6:  tmp <= rf;
      cir_pkg::ST_M7:  cv <= cir_pkg::add_sat(tmp, rf);
      cir_pkg::ST_M8: begin
        tmp <= rf;
        impulse_x <= '0; impulse_y <= '0; outcome <= cir_pkg::OUT_SEPARATING;
      end
      cir_pkg::ST_M9:  x1 <= cir_pkg::sub_sat(tmp, rf);
      cir_pkg::ST_M10: tmp <= rf;
      cir_pkg::ST_M11: x2 <= cir_pkg::sub_sat(tmp, rf);
      cir_pkg::ST_M12: tmp <= rf;
      cir_pkg::ST_M13: tmp2 <= rf;
      cir_pkg::ST_M14: ims <= cir_pkg::add_sat(it.msum, rf);
      cir_pkg::ST_M15: ims <= cir_pkg::add_sat(ims, rf);
      cir_pkg::ST_M17: tx <= cir_pkg::sub_sat(rx, rf);
      cir_pkg::ST_M18: ty <= cir_pkg::sub_sat(ry, rf);
      cir_pkg::ST_M19: sq <= prod[63:0];
      cir_pkg::ST_WJ: begin jj <= div_q; len <= sq_root; end
      cir_pkg::ST_P1:  ix <= rf;
      cir_pkg::ST_P2:  iy <= rf;
      cir_pkg::ST_WTX: tnx <= div_q;
      cir_pkg::ST_WTY: tny <= div_q;
      cir_pkg::ST_J1:  tmp <= rf;
      cir_pkg::ST_WJT: jt <= div_q;
      cir_pkg::ST_F1: begin
        fr <= jt;
        impulse_x <= ix; impulse_y <= iy; outcome <= cir_pkg::OUT_NO_FRICTION;
      end
      cir_pkg::ST_F2:  fr <= rr;
      cir_pkg::ST_F3:  ix <= cir_pkg::add_sat(ix, rf);
      cir_pkg::ST_F4: begin
        impulse_x <= ix; impulse_y <= cir_pkg::add_sat(iy, rf);
        outcome <= cir_pkg::OUT_FULL;
      end
      default: ;
    endcase
  end

endmodule

// File: hdl/contact_impulse_resolver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contact_impulse_resolver
// Impulse with restitution and friction for one 2D rigid body contact.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+--------------------------------
//   input    | start, busy               | body fields, contact point/normal
//   result   | done (one-cycle strobe)   | impulse_x, impulse_y, outcome
//   config   | cfg_valid, cfg_ready      | cfg_index, cfg_data
//
// Most of a contact's time goes to four quotients in the shared serial
// divider; the rest is sequencer steps around the multiplier. A two-entry
// queue accepts new transactions while one is at work. Immovable pairs and
// separating contacts finish early, before the divider is used.
// rst is synchronous; it clears the queue and sequencer and restores defaults.
// The receiver cannot stall: done marks each result for one cycle.
// ----------------------------------------------------------------------------
module contact_impulse_resolver (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [63:0]        body_a_position,
  input  logic [63:0]        body_b_position,
  input  logic [63:0]        body_a_velocity,
  input  logic [63:0]        body_b_velocity,
  input  logic [63:0]        contact_point,
  input  logic [63:0]        contact_normal,
  input  logic signed [31:0] body_a_spin,
  input  logic signed [31:0] body_b_spin,
  input  logic [30:0]        body_a_inv_mass,
  input  logic [30:0]        body_b_inv_mass,
  input  logic [30:0]        body_a_inv_inertia,
  input  logic [30:0]        body_b_inv_inertia,
  output logic               done,
  output logic signed [31:0] impulse_x,
  output logic signed [31:0] impulse_y,
  output logic [1:0]         outcome,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_data
);

  cir_pkg::cfg_t  cfg;
  cir_pkg::item_t q_item;
  logic           q_valid;
  logic           pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.restitution   <= 17'd32768;
      cfg.static_ratio  <= 17'd45875;
      cfg.dynamic_ratio <= 17'd32768;
      cfg.tolerance     <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cir_pkg::cfg_idx_t'(cfg_index))
        cir_pkg::CFG_RESTITUTION:   cfg.restitution   <= cfg_data;
        cir_pkg::CFG_STATIC_RATIO:  cfg.static_ratio  <= cfg_data;
        cir_pkg::CFG_DYNAMIC_RATIO: cfg.dynamic_ratio <= cfg_data;
        cir_pkg::CFG_TOLERANCE:     cfg.tolerance     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  cir_front u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .body_a_position(body_a_position), .body_b_position(body_b_position),
    .body_a_velocity(body_a_velocity), .body_b_velocity(body_b_velocity),
    .contact_point(contact_point), .contact_normal(contact_normal),
    .body_a_spin(body_a_spin), .body_b_spin(body_b_spin),
    .body_a_inv_mass(body_a_inv_mass), .body_b_inv_mass(body_b_inv_mass),
    .body_a_inv_inertia(body_a_inv_inertia),
    .body_b_inv_inertia(body_b_inv_inertia),
    .tolerance(cfg.tolerance), .q_valid(q_valid), .pop(pop), .q_item(q_item)
  );

  cir_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_valid(q_valid), .pop(pop),
    .q_item(q_item), .done(done), .impulse_x(impulse_x),
    .impulse_y(impulse_y), .outcome(outcome)
  );

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe held two cycles");

  a_immovable_zero: assert property (@(posedge clk) disable iff (rst)
    done && (outcome == cir_pkg::OUT_IMMOVABLE || outcome == cir_pkg::OUT_SEPARATING)
    |-> impulse_x == 32'sd0 && impulse_y == 32'sd0)
    else $error("nonzero impulse on a no-impulse outcome");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !done) else $error("result strobe right after reset");

endmodule

// File: bench/impulse_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// impulse_checker
// Watches the contact, result and register channels of the resolver. It
// computes the expected impulse and outcome of every accepted contact with
// its own fixed-point model, queues them, and compares each result field by
// field in order.
// ----------------------------------------------------------------------------
module impulse_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [63:0]        body_a_position,
  input  logic [63:0]        body_b_position,
  input  logic [63:0]        body_a_velocity,
  input  logic [63:0]        body_b_velocity,
  input  logic [63:0]        contact_point,
  input  logic [63:0]        contact_normal,
  input  logic signed [31:0] body_a_spin,
  input  logic signed [31:0] body_b_spin,
  input  logic [30:0]        body_a_inv_mass,
  input  logic [30:0]        body_b_inv_mass,
  input  logic [30:0]        body_a_inv_inertia,
  input  logic [30:0]        body_b_inv_inertia,
  input  logic               done,
  input  logic signed [31:0] impulse_x,
  input  logic signed [31:0] impulse_y,
  input  logic [1:0]         outcome,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_data,
  output int                 fail_count,
  output int                 in_flight
);

  typedef struct {
    logic signed [31:0] ix;
    logic signed [31:0] iy;
    cir_pkg::outcome_t  code;
  } impulse_t;

  localparam longint MAXV = 64'sd2147483647;
  localparam longint MINV = -64'sd2147483648;

  longint bounce, static_ratio, dynamic_ratio, tolerance;
  impulse_t impulse_due[$];

  function automatic longint clip(longint v);
    if (v > MAXV) return MAXV;
    if (v < MINV) return MINV;
    return v;
  endfunction

  function automatic longint rshift(longint p, int s);
    longint half;
    half = longint'(1) <<< (s - 1);
    if (p >= 0) return (p + half) >>> s;
    return -((-p + half) >>> s);
  endfunction

  function automatic longint qadd(longint a, longint b);
    return clip(a + b);
  endfunction

  function automatic longint qsub(longint a, longint b);
    return clip(a - b);
  endfunction

  function automatic longint qmul(longint a, longint b);
    return clip(rshift(a * b, cir_pkg::FRAC_BITS));
  endfunction

  function automatic longint ratio_mul(longint a, longint r);
    return clip(rshift(a * r, cir_pkg::RATIO_BITS));
  endfunction

  function automatic longint qdiv(longint n, longint d);
    longint un, ud, q;
    if (d == 0) begin
      if (n == 0) return 0;
      return n > 0 ? MAXV : MINV;
    end
    un = n < 0 ? -n : n;
    ud = d < 0 ? -d : d;
    q = ((un <<< cir_pkg::FRAC_BITS) + ud / 2) / ud;
    if (q > 64'sh1_0000_0000) q = 64'sh1_0000_0000;
    return clip(((n < 0) != (d < 0)) ? -q : q);
  endfunction

  function automatic longint unsigned root(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic bit near_zero(longint v);
    return (v < 0 ? -v : v) < tolerance;
  endfunction

  function automatic longint lo(logic [63:0] v);
    return longint'($signed(v[31:0]));
  endfunction

  function automatic longint hi(logic [63:0] v);
    return longint'($signed(v[63:32]));
  endfunction

  function automatic impulse_t resolve_contact();
    impulse_t r;
    longint pax, pay, pbx, pby, vax, vay, vbx, vby, cpx, cpy, nx, ny, wa, wb;
    longint msum, c1x, c1y, c2x, c2y, rx, ry, cv, x1, x2, ims, num, j;
    longint tx, ty, tnx, tny, jt, aj, d;
    longint unsigned len;
    pax = lo(body_a_position); pay = hi(body_a_position);
    pbx = lo(body_b_position); pby = hi(body_b_position);
    vax = lo(body_a_velocity); vay = hi(body_a_velocity);
    vbx = lo(body_b_velocity); vby = hi(body_b_velocity);
    cpx = lo(contact_point);   cpy = hi(contact_point);
    nx = lo(contact_normal);   ny = hi(contact_normal);
    wa = longint'(body_a_spin);
    wb = longint'(body_b_spin);
    r.ix = 0;
    r.iy = 0;
    msum = qadd(longint'(body_a_inv_mass), longint'(body_b_inv_mass));
    if (near_zero(msum)) begin
      r.code = cir_pkg::OUT_IMMOVABLE;
      return r;
    end
    c1x = qsub(cpx, pax); c1y = qsub(cpy, pay);
    c2x = qsub(cpx, pbx); c2y = qsub(cpy, pby);
    rx = qadd(vbx, -qmul(wb, c2y));
    ry = qadd(vby, qmul(wb, c2x));
    rx = qsub(qsub(rx, vax), -qmul(wa, c1y));
    ry = qsub(qsub(ry, vay), qmul(wa, c1x));
    cv = qadd(qmul(rx, nx), qmul(ry, ny));
    if (cv > 0) begin
      r.code = cir_pkg::OUT_SEPARATING;
      return r;
    end
    x1 = qsub(qmul(c1x, ny), qmul(c1y, nx));
    x2 = qsub(qmul(c2x, ny), qmul(c2y, nx));
    ims = qadd(msum, qmul(qmul(x1, x1), longint'(body_a_inv_inertia)));
    ims = qadd(ims, qmul(qmul(x2, x2), longint'(body_b_inv_inertia)));
    num = clip(-ratio_mul(cv, cir_pkg::RATIO_ONE + bounce));
    j = qdiv(num, ims);
    r.ix = 32'(qmul(nx, j));
    r.iy = 32'(qmul(ny, j));
    tx = qsub(rx, qmul(nx, cv));
    ty = qsub(ry, qmul(ny, cv));
    len = root(longint'(tx * tx) + longint'(ty * ty));
    if (len == 0) begin
      tnx = 0; tny = 0;
    end else begin
      tnx = qdiv(tx, longint'(len));
      tny = qdiv(ty, longint'(len));
    end
    jt = clip(-qadd(qmul(rx, tnx), qmul(ry, tny)));
    jt = qdiv(jt, ims);
    if (near_zero(jt)) begin
      r.code = cir_pkg::OUT_NO_FRICTION;
      return r;
    end
    aj = jt < 0 ? -jt : jt;
    if (aj < ratio_mul(j, static_ratio)) begin
      r.ix = 32'(qadd(longint'(r.ix), qmul(tnx, jt)));
      r.iy = 32'(qadd(longint'(r.iy), qmul(tny, jt)));
    end else begin
      d = ratio_mul(clip(-j), dynamic_ratio);
      r.ix = 32'(qadd(longint'(r.ix), qmul(tnx, d)));
      r.iy = 32'(qadd(longint'(r.iy), qmul(tny, d)));
    end
    r.code = cir_pkg::OUT_FULL;
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    impulse_t want;
    if (rst) begin
      bounce = 32768;
      static_ratio = 45875;
      dynamic_ratio = 32768;
      tolerance = 1;
      impulse_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cir_pkg::cfg_idx_t'(cfg_index))
          cir_pkg::CFG_RESTITUTION:   bounce = longint'(cfg_data);
          cir_pkg::CFG_STATIC_RATIO:  static_ratio = longint'(cfg_data);
          cir_pkg::CFG_DYNAMIC_RATIO: dynamic_ratio = longint'(cfg_data);
          cir_pkg::CFG_TOLERANCE:     tolerance = longint'(cfg_data[15:0]);
          default: ;
        endcase
      end
      if (done) begin
        if (impulse_due.size() == 0) begin
          report("unexpected result", 0, 0);
        end else begin
          want = impulse_due.pop_front();
          if (impulse_x !== want.ix) report("impulse_x", impulse_x, want.ix);
          if (impulse_y !== want.iy) report("impulse_y", impulse_y, want.iy);
          if (outcome !== want.code) report("outcome", outcome, want.code);
        end
      end
      if (start && !busy) impulse_due.push_back(resolve_contact());
    end
    in_flight <= impulse_due.size();
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives contacts and register writes into the impulse resolver: directed
// corner cases, then random well-formed contacts mixed with raw noise, over
// several register settings with random gaps. The checker judges results.
// ----------------------------------------------------------------------------
module testbench;

  localparam int LIMIT = 3000000;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [63:0]        a_pos, b_pos, a_vel, b_vel, point, normal;
  logic signed [31:0] a_spin, b_spin;
  logic [30:0]        a_im, b_im, a_ii, b_ii;
  logic               done;
  logic signed [31:0] impulse_x, impulse_y;
  logic [1:0]         outcome;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [16:0]        cfg_data;
  int                 fail_count, in_flight, cycles;
  bit                 calm;

  contact_impulse_resolver u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .body_a_position(a_pos), .body_b_position(b_pos),
    .body_a_velocity(a_vel), .body_b_velocity(b_vel),
    .contact_point(point), .contact_normal(normal),
    .body_a_spin(a_spin), .body_b_spin(b_spin),
    .body_a_inv_mass(a_im), .body_b_inv_mass(b_im),
    .body_a_inv_inertia(a_ii), .body_b_inv_inertia(b_ii),
    .done(done), .impulse_x(impulse_x), .impulse_y(impulse_y), .outcome(outcome),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  impulse_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .body_a_position(a_pos), .body_b_position(b_pos),
    .body_a_velocity(a_vel), .body_b_velocity(b_vel),
    .contact_point(point), .contact_normal(normal),
    .body_a_spin(a_spin), .body_b_spin(b_spin),
    .body_a_inv_mass(a_im), .body_b_inv_mass(b_im),
    .body_a_inv_inertia(a_ii), .body_b_inv_inertia(b_ii),
    .done(done), .impulse_x(impulse_x), .impulse_y(impulse_y), .outcome(outcome),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .in_flight(in_flight)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  function automatic logic [63:0] vec(int x, int y);
    return {y, x};
  endfunction

  function automatic int around(int m);
    return int'($urandom_range(0, 2 * m)) - m;
  endfunction

  // random gap before a transaction
  task automatic gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic send_contact(logic [63:0] pa, logic [63:0] pb, logic [63:0] va,
                              logic [63:0] vb, logic [63:0] cp, logic [63:0] n,
                              int wa, int wb, int ma, int mb, int ia, int ib);
    gap();
    a_pos <= pa; b_pos <= pb; a_vel <= va; b_vel <= vb;
    point <= cp; normal <= n; a_spin <= wa; b_spin <= wb;
    a_im <= 31'(ma); b_im <= 31'(mb); a_ii <= 31'(ia); b_ii <= 31'(ib);
    start <= 1;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(cir_pkg::cfg_idx_t idx, int value);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= 17'(value);
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_regs(int e, int s, int d, int tol);
    write_reg(cir_pkg::CFG_RESTITUTION, e);
    write_reg(cir_pkg::CFG_STATIC_RATIO, s);
    write_reg(cir_pkg::CFG_DYNAMIC_RATIO, d);
    write_reg(cir_pkg::CFG_TOLERANCE, tol);
    cfg_valid <= 0;
  endtask

  task automatic random_contact();
    int k, nx, ny;
    k = $urandom_range(0, 9);
    if (k < 2) begin
      send_contact({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                   $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      case ($urandom_range(0, 5))
        0: begin nx = 65536; ny = 0; end
        1: begin nx = 0; ny = -65536; end
        2: begin nx = 46341; ny = -46341; end
        3: begin nx = -46341; ny = 46341; end
        4: begin nx = around(65536); ny = around(65536); end
        default: begin nx = -65536; ny = 0; end
      endcase
      send_contact(vec(around(262144), around(262144)), vec(around(262144), around(262144)),
                   vec(around(524288), around(524288)), vec(around(524288), around(524288)),
                   vec(around(262144), around(262144)), vec(nx, ny),
                   ($urandom_range(0, 3) == 0) ? 0 : around(131072),
                   ($urandom_range(0, 3) == 0) ? 0 : around(131072),
                   ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 131072),
                   ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 131072),
                   ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 131072),
                   $urandom_range(0, 131072));
    end
  endtask

  initial begin
    int sizes[5];
    calm = 0;
    rst = 1;
    start = 0;
    cfg_valid = 0;
    cfg_index = cir_pkg::CFG_RESTITUTION;
    cfg_data = 0;
    a_pos = 0; b_pos = 0; a_vel = 0; b_vel = 0; point = 0; normal = 0;
    a_spin = 0; b_spin = 0; a_im = 0; b_im = 0; a_ii = 0; b_ii = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // immovable pair
    send_contact(0, vec(65536, 0), vec(65536, 0), 0, vec(32768, 0), vec(65536, 0),
                 0, 0, 0, 0, 100, 100);
    // separating
    send_contact(0, vec(131072, 0), 0, vec(65536, 0), vec(65536, 0), vec(65536, 0),
                 0, 0, 65536, 65536, 0, 0);
    // head-on, no tangent: normal impulse only
    send_contact(0, vec(131072, 0), vec(65536, 0), vec(-65536, 0), vec(65536, 0),
                 vec(65536, 0), 0, 0, 65536, 65536, 0, 0);
    // small slide: static friction
    send_contact(0, vec(0, 131072), vec(0, 65536), vec(6554, -65536), vec(0, 65536),
                 vec(0, 65536), 0, 0, 65536, 65536, 65536, 65536);
    // large slide: dynamic friction
    send_contact(0, vec(0, 131072), vec(0, 65536), vec(655360, -65536), vec(0, 65536),
                 vec(0, 65536), 0, 0, 65536, 65536, 65536, 65536);
    // spinning bodies, diagonal normal
    send_contact(0, vec(131072, 131072), vec(65536, 65536), 0, vec(65536, 65536),
                 vec(46341, 46341), 65536, -65536, 65536, 32768, 65536, 65536);
    // unnormalized normal
    send_contact(0, vec(131072, 0), vec(65536, 0), vec(-65536, 3000), vec(65536, 0),
                 vec(300000, 0), 0, 0, 65536, 65536, 0, 0);
    // extremes
    send_contact('1, '1, '1, '1, '1, '1, -1, -1, 31'h7FFFFFFF, 31'h7FFFFFFF,
                 31'h7FFFFFFF, 31'h7FFFFFFF);
    send_contact({2{32'h80000000}}, {2{32'h7FFFFFFF}}, {2{32'h7FFFFFFF}},
                 {2{32'h80000000}}, {2{32'h80000000}}, {2{32'h7FFFFFFF}},
                 32'sh80000000, 32'sh7FFFFFFF, 31'h7FFFFFFF, 0, 0, 31'h7FFFFFFF);
    send_contact({2{32'h7FFFFFFF}}, {2{32'h80000000}}, {2{32'h80000000}},
                 {2{32'h7FFFFFFF}}, {2{32'h7FFFFFFF}}, {2{32'h80000000}},
                 32'sh7FFFFFFF, 32'sh80000000, 1, 0, 31'h7FFFFFFF, 0);
    send_contact(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0);
    send_contact(0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0);
    drain();

    sizes = '{350, 350, 350, 350, 350};
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: set_regs(0, 0, 0, 0);
        1: set_regs(65536, 65536, 65536, 65535);
        2: set_regs(65536, 0, 65536, 0);
        3: set_regs($urandom_range(0, 65536), $urandom_range(0, 65536),
                    $urandom_range(0, 65536), $urandom_range(0, 64));
        default: set_regs(32768, 45875, 32768, 1);
      endcase
      for (int i = 0; i < sizes[p]; i++) begin
        calm = (p == 4 && i >= sizes[p] - 300);
        random_contact();
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/cir_pkg.sv
hdl/cir_div.sv
hdl/cir_sqrt.sv
hdl/cir_front.sv
hdl/cir_back.sv
hdl/contact_impulse_resolver.sv
bench/impulse_checker.sv
bench/testbench.sv
